@@ rtl/glcd_pkg.sv @@
// shared types, constants and font table for the glcd text line writer
`default_nettype none
package glcd_pkg;

  localparam int HALF_COLUMNS = 64;
  localparam int GLYPH_WIDTH  = 5;
  localparam int FONT_COLS    = 5;
  localparam int FONT_ENTRIES = 96;
  localparam int FIRST_CHAR   = 32;
  localparam int SETUP_STEPS  = 4;

  localparam int COL_W  = $clog2(HALF_COLUMNS + 1);
  localparam int GI_W   = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
  localparam int FC_W   = $clog2(FONT_COLS);
  localparam int IDX_W  = $clog2(FONT_ENTRIES);
  localparam int STEP_W = $clog2(SETUP_STEPS);

  localparam logic [STEP_W-1:0] SETUP_LAST = STEP_W'(SETUP_STEPS - 1);

  localparam logic CFG_LEFT_MARGIN = 1'b0;
  localparam logic CFG_START_LINE  = 1'b1;

  localparam logic [5:0] LEFT_MARGIN_RESET = 6'd5;
  localparam logic [5:0] START_LINE_RESET  = 6'd0;

  localparam logic [7:0] DISPLAY_ON_ARG = 8'h01;
  localparam logic [7:0] BLANK_COLUMN   = 8'h00;

  typedef enum logic [1:0] {
    CMD_DISPLAY_ON,
    CMD_SET_COLUMN,
    CMD_SET_PAGE,
    CMD_SET_START_LINE
  } cmd_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_GLYPH,
    ST_GAP_CMD,
    ST_GAP_DATA
  } glcd_state_t;

  typedef struct packed {
    logic             is_start;
    logic [2:0]       page;
    logic [IDX_W-1:0] glyph_idx;
  } glcd_item_t;

  typedef struct packed {
    logic [5:0] left_margin;
    logic [5:0] scroll_line;
  } glcd_cfg_t;

  localparam logic [7:0] FONT_ROM [FONT_ENTRIES][FONT_COLS] = '{
    '{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h5f,8'h00,8'h00},
    '{8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h14,8'h7f,8'h14,8'h7f,8'h14},
    '{8'h24,8'h2a,8'h7f,8'h2a,8'h12}, '{8'h23,8'h13,8'h08,8'h64,8'h62},
    '{8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h05,8'h03,8'h00,8'h00},
    '{8'h00,8'h1c,8'h22,8'h41,8'h00}, '{8'h00,8'h41,8'h22,8'h1c,8'h00},
    '{8'h14,8'h08,8'h3e,8'h08,8'h14}, '{8'h08,8'h08,8'h3e,8'h08,8'h08},
    '{8'h00,8'h50,8'h30,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
    '{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02},
    '{8'h3e,8'h51,8'h49,8'h45,8'h3e}, '{8'h00,8'h42,8'h7f,8'h40,8'h00},
    '{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4b,8'h31},
    '{8'h18,8'h14,8'h12,8'h7f,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
    '{8'h3c,8'h4a,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
    '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1e},
    '{8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00},
    '{8'h08,8'h14,8'h22,8'h41,8'h00}, '{8'h14,8'h14,8'h14,8'h14,8'h14},
    '{8'h00,8'h41,8'h22,8'h14,8'h08}, '{8'h02,8'h01,8'h51,8'h09,8'h06},
    '{8'h32,8'h49,8'h79,8'h41,8'h3e}, '{8'h7e,8'h11,8'h11,8'h11,8'h7e},
    '{8'h7f,8'h49,8'h49,8'h49,8'h36}, '{8'h3e,8'h41,8'h41,8'h41,8'h22},
    '{8'h7f,8'h41,8'h41,8'h22,8'h1c}, '{8'h7f,8'h49,8'h49,8'h49,8'h41},
    '{8'h7f,8'h09,8'h09,8'h09,8'h01}, '{8'h3e,8'h41,8'h49,8'h49,8'h7a},
    '{8'h7f,8'h08,8'h08,8'h08,8'h7f}, '{8'h00,8'h41,8'h7f,8'h41,8'h00},
    '{8'h20,8'h40,8'h41,8'h3f,8'h01}, '{8'h7f,8'h08,8'h14,8'h22,8'h41},
    '{8'h7f,8'h40,8'h40,8'h40,8'h40}, '{8'h7f,8'h02,8'h0c,8'h02,8'h7f},
    '{8'h7f,8'h04,8'h08,8'h10,8'h7f}, '{8'h3e,8'h41,8'h41,8'h41,8'h3e},
    '{8'h7f,8'h09,8'h09,8'h09,8'h06}, '{8'h3e,8'h41,8'h51,8'h21,8'h5e},
    '{8'h7f,8'h09,8'h19,8'h29,8'h46}, '{8'h46,8'h49,8'h49,8'h49,8'h31},
    '{8'h01,8'h01,8'h7f,8'h01,8'h01}, '{8'h3f,8'h40,8'h40,8'h40,8'h3f},
    '{8'h1f,8'h20,8'h40,8'h20,8'h1f}, '{8'h3f,8'h40,8'h38,8'h40,8'h3f},
    '{8'h63,8'h14,8'h08,8'h14,8'h63}, '{8'h07,8'h08,8'h70,8'h08,8'h07},
    '{8'h61,8'h51,8'h49,8'h45,8'h43}, '{8'h00,8'h7f,8'h41,8'h41,8'h00},
    '{8'h02,8'h04,8'h08,8'h10,8'h20}, '{8'h00,8'h41,8'h41,8'h7f,8'h00},
    '{8'h04,8'h02,8'h01,8'h02,8'h04}, '{8'h40,8'h40,8'h40,8'h40,8'h40},
    '{8'h00,8'h01,8'h02,8'h04,8'h00}, '{8'h20,8'h54,8'h54,8'h54,8'h78},
    '{8'h7f,8'h48,8'h44,8'h44,8'h38}, '{8'h38,8'h44,8'h44,8'h44,8'h20},
    '{8'h38,8'h44,8'h44,8'h48,8'h7f}, '{8'h38,8'h54,8'h54,8'h54,8'h18},
    '{8'h08,8'h7e,8'h09,8'h01,8'h02}, '{8'h0c,8'h52,8'h52,8'h52,8'h3e},
    '{8'h7f,8'h08,8'h04,8'h04,8'h78}, '{8'h00,8'h44,8'h7d,8'h40,8'h00},
    '{8'h20,8'h40,8'h44,8'h3d,8'h00}, '{8'h7f,8'h10,8'h28,8'h44,8'h00},
    '{8'h00,8'h41,8'h7f,8'h40,8'h00}, '{8'h7c,8'h04,8'h18,8'h04,8'h78},
    '{8'h7c,8'h08,8'h04,8'h04,8'h78}, '{8'h38,8'h44,8'h44,8'h44,8'h38},
    '{8'h7c,8'h14,8'h14,8'h14,8'h08}, '{8'h08,8'h14,8'h14,8'h18,8'h7c},
    '{8'h7c,8'h08,8'h04,8'h04,8'h08}, '{8'h48,8'h54,8'h54,8'h54,8'h20},
    '{8'h04,8'h3f,8'h44,8'h40,8'h20}, '{8'h3c,8'h40,8'h40,8'h20,8'h7c},
    '{8'h1c,8'h20,8'h40,8'h20,8'h1c}, '{8'h3c,8'h40,8'h30,8'h40,8'h3c},
    '{8'h44,8'h28,8'h10,8'h28,8'h44}, '{8'h0c,8'h50,8'h50,8'h50,8'h3c},
    '{8'h44,8'h64,8'h54,8'h4c,8'h44}, '{8'h00,8'h08,8'h36,8'h41,8'h00},
    '{8'h00,8'h00,8'h7f,8'h00,8'h00}, '{8'h00,8'h41,8'h36,8'h08,8'h00},
    '{8'h10,8'h08,8'h08,8'h10,8'h08}, '{8'h78,8'h46,8'h41,8'h46,8'h78}
  };

  function automatic logic [7:0] glyph_column(input logic [IDX_W-1:0] idx,
                                              input logic [FC_W-1:0] col);
    return FONT_ROM[idx][col];
  endfunction

  // codes below the first printable character draw as a space
  function automatic logic [IDX_W-1:0] font_index(input logic [6:0] ch);
    logic [6:0] offs;
    offs = ch - 7'(FIRST_CHAR);
    if (ch < 7'(FIRST_CHAR)) begin
      return '0;
    end
    return IDX_W'(offs);
  endfunction

endpackage
`default_nettype wire

@@ rtl/glcd_if.sv @@
// valid/ready channel interfaces for input items and display bus writes
`default_nettype none
interface glcd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [2:0] page;
  logic [6:0] character;

  modport source (output valid, output op, output page, output character, input ready);
  modport sink (input valid, input op, input page, input character, output ready);
endinterface

interface glcd_out_if;
  logic       valid;
  logic       ready;
  logic       is_command;
  logic [1:0] command_kind;
  logic [7:0] value;
  logic       half_select;
  logic       last;

  modport source (output valid, output is_command, output command_kind, output value,
                  output half_select, output last, input ready);
  modport sink (input valid, input is_command, input command_kind, input value,
                input half_select, input last, output ready);
endinterface
`default_nettype wire

@@ rtl/glcd_text_line_writer.sv @@
// Text line writer for a two-half 128x64 graphic display with a 5x7 font.
// in_chan carries one word per item: op 0 starts a line on the given page,
// op 1 draws one character. out_chan carries display bus writes: command or
// data, command kind, value, chip half and a last flag on the final write
// of each item. A start item gives four set-up writes; a character gives
// five glyph columns plus a set-column command and a blank gap column, with
// four extra set-up writes when the line crosses to the right half (up to
// eleven writes). Characters on a full line give no writes.
// The back end emits one write per cycle while out_chan is not stalled;
// each item is first taken from the queue in the idle state, and a
// character gives fewer writes when the gap is skipped at an edge. The front
// end takes a new word every cycle while its two-entry queue has room, so
// in_chan.ready can stay high while the back end works on an earlier item.
// A stalled out_chan holds the write in the output register; the back end
// stops, the queue fills and in_chan.ready then drops.
// Reset (rst_n low, synchronous) empties the queue and output register,
// puts the line at page 0, column 0 of the left half, sets left_margin to 5
// and the start line to 0. cfg_we writes cfg_data to register cfg_index:
// 0 left_margin, 1 display_start_line.
`default_nettype none
module glcd_text_line_writer
  import glcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  glcd_in_if.sink         in_chan,
  glcd_out_if.source      out_chan,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [5:0] cfg_data
);

  glcd_cfg_t  cfg_r, cfg_nxt;
  glcd_item_t q_item;
  logic       q_valid;
  logic       q_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_LEFT_MARGIN: cfg_nxt.left_margin = cfg_data;
        CFG_START_LINE:  cfg_nxt.scroll_line = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left_margin <= LEFT_MARGIN_RESET;
      cfg_r.scroll_line <= START_LINE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  glcd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  glcd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_item   (q_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire

@@ rtl/glcd_front.sv @@
// front end: classifies input words and holds them in a two-entry queue
`default_nettype none
module glcd_front
  import glcd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  glcd_in_if.sink     in_chan,
  output glcd_item_t  q_item,
  output logic        q_valid,
  input  wire logic   q_ready
);

  glcd_item_t queue_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;
  glcd_item_t item_in;

  assign in_chan.ready = (count_r != 2'd2);
  assign push          = in_chan.valid && in_chan.ready;
  assign q_valid       = (count_r != 2'd0);
  assign pop           = q_valid && q_ready;
  assign q_item        = queue_r[rd_ptr_r];

  always_comb begin
    item_in.is_start  = (in_chan.op == 1'b0);
    item_in.page      = in_chan.page;
    item_in.glyph_idx = font_index(in_chan.character);
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= item_in;
    end
  end

endmodule
`default_nettype wire

@@ rtl/glcd_back.sv @@
// back end: sequences set-up, glyph and gap writes into the output register
`default_nettype none
module glcd_back
  import glcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire glcd_cfg_t  cfg,
  input  wire glcd_item_t q_item,
  input  wire logic       q_valid,
  output logic            q_ready,
  glcd_out_if.source      out_chan
);

  glcd_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [GI_W-1:0]   gi_r, gi_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [2:0]        page_r, page_nxt;
  logic              right_r, right_nxt;
  logic              full_r, full_nxt;
  logic              wrap_r, wrap_nxt;

  logic              out_valid_r;
  logic              out_cmd_r;
  logic [1:0]        out_kind_r;
  logic [7:0]        out_value_r;
  logic              out_half_r;
  logic              out_last_r;

  logic              adv;
  logic              emit;
  logic              emit_cmd;
  cmd_kind_t         emit_kind;
  logic [7:0]        emit_value;
  logic              emit_last;
  logic [COL_W-1:0]  col_inc;
  logic              at_edge;
  logic              gi_end;
  logic              glyph_last;
  logic              col_past_half;

  assign adv           = !out_valid_r || out_chan.ready;
  assign q_ready       = (state_r == ST_IDLE);
  assign col_inc       = col_r + COL_W'(1);
  assign at_edge       = (col_inc >= COL_W'(HALF_COLUMNS));
  assign col_past_half = (col_r >= COL_W'(HALF_COLUMNS));
  assign gi_end        = (({1'b0, gi_r} + (GI_W+1)'(1)) == (GI_W+1)'(GLYPH_WIDTH));
  assign glyph_last    = at_edge && (right_r || gi_end);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_item.is_start) begin
            state_nxt = ST_SETUP;
          end else if (full_r) begin
            state_nxt = ST_IDLE;
          end else if (col_past_half) begin
            state_nxt = ST_SETUP;
          end else begin
            state_nxt = ST_GLYPH;
          end
        end
      end
      ST_SETUP: begin
        if (adv && step_r == SETUP_LAST) begin
          state_nxt = wrap_r ? ST_GLYPH : ST_IDLE;
        end
      end
      ST_GLYPH: begin
        if (adv) begin
          if (glyph_last) begin
            state_nxt = ST_IDLE;
          end else if (at_edge) begin
            state_nxt = ST_SETUP;
          end else if (gi_end) begin
            state_nxt = ST_GAP_CMD;
          end else begin
            state_nxt = ST_GLYPH;
          end
        end
      end
      ST_GAP_CMD: begin
        if (adv) begin
          state_nxt = ST_GAP_DATA;
        end
      end
      ST_GAP_DATA: begin
        if (adv) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // write fields and line position updates
  always_comb begin
    emit       = 1'b0;
    emit_cmd   = 1'b0;
    emit_kind  = CMD_DISPLAY_ON;
    emit_value = BLANK_COLUMN;
    emit_last  = 1'b0;
    step_nxt   = step_r;
    gi_nxt     = gi_r;
    idx_nxt    = idx_r;
    col_nxt    = col_r;
    page_nxt   = page_r;
    right_nxt  = right_r;
    full_nxt   = full_r;
    wrap_nxt   = wrap_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          step_nxt = '0;
          gi_nxt   = '0;
          idx_nxt  = q_item.glyph_idx;
          if (q_item.is_start) begin
            page_nxt  = q_item.page;
            col_nxt   = COL_W'(cfg.left_margin);
            right_nxt = 1'b0;
            full_nxt  = 1'b0;
            wrap_nxt  = 1'b0;
          end else if (!full_r && col_past_half) begin
            right_nxt = 1'b1;
            col_nxt   = '0;
            wrap_nxt  = 1'b1;
          end
        end
      end
      ST_SETUP: begin
        emit     = 1'b1;
        emit_cmd = 1'b1;
        case (step_r)
          2'd0: begin
            emit_kind  = CMD_DISPLAY_ON;
            emit_value = DISPLAY_ON_ARG;
          end
          2'd1: begin
            emit_kind  = CMD_SET_COLUMN;
            emit_value = 8'(col_r);
          end
          2'd2: begin
            emit_kind  = CMD_SET_PAGE;
            emit_value = 8'(page_r);
          end
          default: begin
            emit_kind  = CMD_SET_START_LINE;
            emit_value = 8'(cfg.scroll_line);
          end
        endcase
        emit_last = (step_r == SETUP_LAST) && !wrap_r;
        if (adv) begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_GLYPH: begin
        emit       = 1'b1;
        emit_value = (32'(gi_r) < FONT_COLS) ? glyph_column(idx_r, FC_W'(gi_r)) : BLANK_COLUMN;
        emit_last  = glyph_last;
        if (adv) begin
          gi_nxt  = gi_r + GI_W'(1);
          col_nxt = col_inc;
          if (at_edge && right_r) begin
            full_nxt = 1'b1;
          end else if (at_edge && !gi_end) begin
            right_nxt = 1'b1;
            col_nxt   = '0;
            wrap_nxt  = 1'b1;
            step_nxt  = '0;
          end
        end
      end
      ST_GAP_CMD: begin
        emit       = 1'b1;
        emit_cmd   = 1'b1;
        emit_kind  = CMD_SET_COLUMN;
        emit_value = 8'(col_r);
      end
      ST_GAP_DATA: begin
        emit      = 1'b1;
        emit_last = 1'b1;
        if (adv) begin
          col_nxt = col_inc;
          if (right_r && at_edge) begin
            full_nxt = 1'b1;
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      gi_r        <= '0;
      col_r       <= '0;
      page_r      <= 3'd0;
      right_r     <= 1'b0;
      full_r      <= 1'b0;
      wrap_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      gi_r    <= gi_nxt;
      col_r   <= col_nxt;
      page_r  <= page_nxt;
      right_r <= right_nxt;
      full_r  <= full_nxt;
      wrap_r  <= wrap_nxt;
      if (adv) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (adv && emit) begin
      out_cmd_r   <= emit_cmd;
      out_kind_r  <= emit_kind;
      out_value_r <= emit_value;
      out_half_r  <= right_r;
      out_last_r  <= emit_last;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.is_command   = out_cmd_r;
  assign out_chan.command_kind = out_kind_r;
  assign out_chan.value        = out_value_r;
  assign out_chan.half_select  = out_half_r;
  assign out_chan.last         = out_last_r;

endmodule
`default_nettype wire

@@ rtl/glcd_checker.sv @@
// port-level checks for the glcd text line writer, bound to the top level
`default_nettype none
module glcd_checker
  import glcd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_is_command,
  input wire logic [1:0] out_command_kind,
  input wire logic [7:0] out_value,
  input wire logic       out_half_select,
  input wire logic       out_last
);

  // a stalled word stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out word dropped while stalled");

  // a stalled word keeps its value, last flag, command flag and half select
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_last)
      && $stable(out_is_command) && $stable(out_half_select))
    else $error("out payload changed while stalled");

  // display on always carries its fixed argument and never ends an item
  a_display_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_command && out_command_kind == CMD_DISPLAY_ON
      |-> out_value == DISPLAY_ON_ARG && !out_last)
    else $error("bad display on write");

  // only a start item ends on set start line, and that is on the left half
  a_setup_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && out_is_command
      |-> out_command_kind == CMD_SET_START_LINE && !out_half_select)
    else $error("item ended on an unexpected command");

endmodule

bind glcd_text_line_writer glcd_checker u_glcd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_is_command   (out_chan.is_command),
  .out_command_kind (out_chan.command_kind),
  .out_value        (out_chan.value),
  .out_half_select  (out_chan.half_select),
  .out_last         (out_chan.last)
);
`default_nettype wire
